>>> sv/ipv6p_pkg.sv
// Shared types, constants and helper functions for the IPv6 text address parser.
// No dependencies.
package ipv6p_pkg;

  localparam int GroupCount  = 8;
  localparam int GroupIdxW   = $clog2(GroupCount);
  localparam int GroupCntW   = GroupIdxW + 1;
  localparam int GroupW      = 16;
  localparam int DigitsMax   = 4;
  localparam int DigitCntW   = 3;
  localparam int CharCntW    = 6;
  localparam int MaxTextLen  = 8 * 4 + 7;

  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowF  = 8'h66;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StTooLong   = 3'd1,
    StGroupLong = 3'd2,
    StTwoGaps   = 3'd3,
    StBadHex    = 3'd4,
    StTooMany   = 3'd5
  } status_e;

  typedef logic [GroupW-1:0] group_t;

  function automatic logic [1:0] err_rank(status_e e);
    logic [1:0] r;
    case (e)
      StGroupLong, StTwoGaps: r = 2'd2;
      StBadHex, StTooMany:    r = 2'd1;
      default:                r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic status_e err_raise(status_e cur, status_e e);
    return (err_rank(e) > err_rank(cur)) ? e : cur;
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return c inside {[CharZero:CharNine], [CharLowA:CharLowF], [CharUpA:CharUpF]};
  endfunction

  function automatic logic [3:0] hex_nibble(logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c inside {[CharZero:CharNine]}) begin
      v = 4'(c - CharZero);
    end else if (c inside {[CharLowA:CharLowF]}) begin
      v = 4'(c - CharLowA + 8'd10);
    end else if (c inside {[CharUpA:CharUpF]}) begin
      v = 4'(c - CharUpA + 8'd10);
    end
    return v;
  endfunction

endpackage

>>> sv/ipv6_text_address_parser.sv
// IPv6 text address parser: character register, parse state and result register.
// Depends on ipv6p_pkg.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o | char_code_i, last_char_i
//  out     | output    | out_valid_o / out_stall_i | addr_high_o, addr_low_o, status_o
//
// One character per cycle unless a last character waits on a stalled result; an
// address enters the result register as its last character is parsed.
// The parse state and gap expansion sit in one logic stage between the two registers.
// Reset clears all parse state and both valid flags; the parser is ready at once.
// A stalled result blocks only a last character; other characters keep flowing.
module ipv6_text_address_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                char_code_i,
  input  logic                      last_char_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [63:0]               addr_high_o,
  output logic [63:0]               addr_low_o,
  output logic [2:0]                status_o
);
  import ipv6p_pkg::*;

  logic                  s1_valid_q;
  logic [7:0]            s1_char_q;
  logic                  s1_last_q;
  logic                  out_valid_q;
  logic [63:0]           addr_high_q, addr_high_d;
  logic [63:0]           addr_low_q, addr_low_d;
  status_e               status_q, status_d;

  group_t                store_q [GroupCount];
  group_t                store_d [GroupCount];
  group_t                cur_q, cur_d;
  logic [DigitCntW-1:0]  dcnt_q, dcnt_d;
  logic [GroupCntW-1:0]  gidx_q, gidx_d;
  logic [CharCntW-1:0]   ccnt_q, ccnt_d;
  logic                  gap_q, gap_d;
  logic [GroupCntW-1:0]  gpos_q, gpos_d;
  logic                  prev_q, prev_d;
  status_e               err_q, err_d;

  logic                  out_free, s1_fire, in_accept;
  logic                  hex_ok, do_close;
  group_t                full [GroupCount];
  logic [GroupCntW-1:0]  shift;
  logic [GroupCntW:0]    gap_end;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && (!s1_last_q || out_free);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    store_d  = store_q;
    cur_d    = cur_q;
    dcnt_d   = dcnt_q;
    gidx_d   = gidx_q;
    gap_d    = gap_q;
    gpos_d   = gpos_q;
    prev_d   = prev_q;
    err_d    = err_q;
    do_close = 1'b0;
    hex_ok   = is_hex(s1_char_q);
    ccnt_d   = (ccnt_q == '1) ? ccnt_q : ccnt_q + 1'b1;

    if (s1_char_q == CharColon) begin
      if (prev_q) begin
        if (gap_q) begin
          err_d = err_raise(err_d, StTwoGaps);
        end else begin
          gap_d  = 1'b1;
          gpos_d = gidx_q;
        end
      end else if (ccnt_q != '0) begin
        do_close = 1'b1;
      end
      prev_d = 1'b1;
    end else begin
      if (dcnt_q >= DigitCntW'(DigitsMax)) begin
        err_d = err_raise(err_d, StGroupLong);
      end else begin
        dcnt_d = dcnt_q + 1'b1;
        if (hex_ok) begin
          cur_d = {cur_q[GroupW-5:0], hex_nibble(s1_char_q)};
        end
      end
      if (!hex_ok) begin
        err_d = err_raise(err_d, StBadHex);
      end
      prev_d = 1'b0;
      do_close = s1_last_q;
    end

    if (do_close) begin
      if (gidx_q >= GroupCntW'(GroupCount)) begin
        err_d = err_raise(err_d, StTooMany);
      end else begin
        store_d[gidx_q[GroupIdxW-1:0]] = cur_d;
        gidx_d = gidx_q + 1'b1;
      end
      cur_d  = '0;
      dcnt_d = '0;
    end

    if (s1_last_q && gap_d && gidx_d >= GroupCntW'(GroupCount)) begin
      err_d = err_raise(err_d, StTooMany);
    end
    status_d = (ccnt_d > CharCntW'(MaxTextLen)) ? StTooLong : err_d;

    // expand the gap: groups at and after it move up by the number of missing groups
    shift   = GroupCntW'(GroupCount) - gidx_d;
    gap_end = {1'b0, gpos_d} + {1'b0, shift};
    for (int j = 0; j < GroupCount; j++) begin
      if (!gap_d || (GroupCntW + 1)'(j) < {1'b0, gpos_d}) begin
        full[j] = store_d[j];
      end else if ((GroupCntW + 1)'(j) >= gap_end) begin
        full[j] = store_d[GroupIdxW'(GroupCntW'(j) - shift)];
      end else begin
        full[j] = '0;
      end
      if (status_d != StOk) begin
        full[j] = '0;
      end
    end
    addr_high_d = {full[0], full[1], full[2], full[3]};
    addr_low_d  = {full[4], full[5], full[6], full[7]};

    if (s1_last_q) begin
      for (int j = 0; j < GroupCount; j++) begin
        store_d[j] = '0;
      end
      cur_d  = '0;
      dcnt_d = '0;
      gidx_d = '0;
      ccnt_d = '0;
      gap_d  = 1'b0;
      gpos_d = '0;
      prev_d = 1'b0;
      err_d  = StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire && s1_last_q) begin
        out_valid_q <= 1'b1;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < GroupCount; j++) begin
        store_q[j] <= '0;
      end
      cur_q  <= '0;
      dcnt_q <= '0;
      gidx_q <= '0;
      ccnt_q <= '0;
      gap_q  <= 1'b0;
      gpos_q <= '0;
      prev_q <= 1'b0;
      err_q  <= StOk;
    end else if (s1_fire) begin
      store_q <= store_d;
      cur_q   <= cur_d;
      dcnt_q  <= dcnt_d;
      gidx_q  <= gidx_d;
      ccnt_q  <= ccnt_d;
      gap_q   <= gap_d;
      gpos_q  <= gpos_d;
      prev_q  <= prev_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_char_q <= char_code_i;
      s1_last_q <= last_char_i;
    end
    if (s1_fire && s1_last_q) begin
      addr_high_q <= addr_high_d;
      addr_low_q  <= addr_low_d;
      status_q    <= status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign addr_high_o = addr_high_q;
  assign addr_low_o  = addr_low_q;
  assign status_o    = status_q;

`ifndef SYNTHESIS
  a_err_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != StOk |-> addr_high_q == '0 && addr_low_q == '0)
    else $error("error result carries a nonzero address");

  a_gidx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gidx_q <= GroupCntW'(GroupCount) && gpos_q <= gidx_q)
    else $error("group index or gap position out of range");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_last_q |=> ccnt_q == '0 && gidx_q == '0 && !gap_q && err_q == StOk)
    else $error("parse state not cleared after last character");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s1_last_q && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked result");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_last_q |=> out_valid_q)
    else $error("last character produced no result");
`endif

endmodule

>>> test/ipv6_text_address_parser_tb.sv
// Self-checking testbench for ipv6_text_address_parser: streams address text one character
// per transaction and compares each address and status with an in-bench predictor.
// Depends on ipv6p_pkg and the parser RTL.
module ipv6_text_address_parser_tb;
  import ipv6p_pkg::*;

  typedef struct packed {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    status_e     status;
  } addr_result_t;

  class addr_scoreboard;
    group_t       groups [GroupCount];
    group_t       cur_group;
    logic [2:0]   digit_cnt;
    logic [3:0]   grp_idx;
    logic [5:0]   char_cnt;
    logic         gap_seen;
    logic [3:0]   gap_pos;
    logic         prev_colon;
    status_e      err;
    addr_result_t expected_q[$];
    int           failures;

    function new();
      failures = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      foreach (groups[i]) groups[i] = '0;
      cur_group  = '0;
      digit_cnt  = '0;
      grp_idx    = '0;
      char_cnt   = '0;
      gap_seen   = 1'b0;
      gap_pos    = '0;
      prev_colon = 1'b0;
      err        = StOk;
    endfunction

    function int rank(status_e e);
      if (e == StGroupLong || e == StTwoGaps) return 2;
      if (e == StBadHex || e == StTooMany) return 1;
      return 0;
    endfunction

    function void raise(status_e e);
      if (rank(e) > rank(err)) err = e;
    endfunction

    function void close_group();
      if (grp_idx >= GroupCount) begin
        raise(StTooMany);
      end else begin
        groups[grp_idx] = cur_group;
        grp_idx++;
      end
      cur_group = '0;
      digit_cnt = '0;
    endfunction

    function void note_char(logic [7:0] c, logic is_last);
      logic         first;
      int           v;
      int           shift;
      int           dst;
      group_t       full [GroupCount];
      status_e      st;
      addr_result_t res;
      first = (char_cnt == 0);
      if (char_cnt < 6'd63) char_cnt++;
      if (c == CharColon) begin
        if (prev_colon) begin
          if (gap_seen) begin
            raise(StTwoGaps);
          end else begin
            gap_seen = 1'b1;
            gap_pos  = grp_idx;
          end
        end else if (!first) begin
          close_group();
        end
        prev_colon = 1'b1;
      end else begin
        v = -1;
        if (c >= CharZero && c <= CharNine) v = int'(c - CharZero);
        else if (c >= CharLowA && c <= CharLowF) v = int'(c - CharLowA) + 10;
        else if (c >= CharUpA && c <= CharUpF) v = int'(c - CharUpA) + 10;
        if (digit_cnt >= DigitsMax) begin
          raise(StGroupLong);
        end else begin
          digit_cnt++;
          if (v >= 0) cur_group = {cur_group[11:0], 4'(v)};
        end
        if (v < 0) raise(StBadHex);
        prev_colon = 1'b0;
        if (is_last) close_group();
      end
      if (!is_last) return;
      if (gap_seen && grp_idx >= GroupCount) raise(StTooMany);
      st = err;
      if (char_cnt > MaxTextLen) st = StTooLong;
      foreach (full[i]) full[i] = '0;
      if (st == StOk) begin
        shift = gap_seen ? GroupCount - int'(grp_idx) : 0;
        for (int i = 0; i < int'(grp_idx); i++) begin
          dst = (gap_seen && i >= int'(gap_pos)) ? i + shift : i;
          full[dst] = groups[i];
        end
      end
      res.addr_high = {full[0], full[1], full[2], full[3]};
      res.addr_low  = {full[4], full[5], full[6], full[7]};
      res.status    = st;
      expected_q.insert(expected_q.size(), res);
      clear_parse();
    endfunction

    function void check_addr(logic [63:0] hi, logic [63:0] lo, logic [2:0] st);
      addr_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("unexpected result: addr_high %h addr_low %h status %0d", hi, lo, st);
        failures++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (hi !== exp_r.addr_high) begin
        $error("addr_high: expected %h, actual %h", exp_r.addr_high, hi);
        failures++;
      end
      if (lo !== exp_r.addr_low) begin
        $error("addr_low: expected %h, actual %h", exp_r.addr_low, lo);
        failures++;
      end
      if (st !== exp_r.status) begin
        $error("status: expected %0d, actual %0d", exp_r.status, st);
        failures++;
      end
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  char_code_i = 8'h00;
  logic        last_char_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] addr_high_o;
  logic [63:0] addr_low_o;
  logic [2:0]  status_o;

  addr_scoreboard parser_sb = new();
  logic [7:0]     addr_text[$];
  bit             calm = 1'b0;
  int unsigned    stall_left = 0;
  int unsigned    chars_sent = 0;
  int unsigned    addrs_sent = 0;

  ipv6_text_address_parser u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .char_code_i(char_code_i),
    .last_char_i(last_char_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .addr_high_o(addr_high_o),
    .addr_low_o (addr_low_o),
    .status_o   (status_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void add_char(logic [7:0] c);
    addr_text.insert(addr_text.size(), c);
  endfunction

  function automatic logic [7:0] hex_char(int unsigned nib);
    if (nib < 10) return CharZero + 8'(nib);
    return ($urandom_range(0, 1) ? CharUpA : CharLowA) + 8'(nib - 10);
  endfunction

  function automatic void push_groups(int unsigned count, int unsigned min_d,
                                      int unsigned max_d);
    for (int i = 0; i < int'(count); i++) begin
      if (i != 0) add_char(CharColon);
      repeat ($urandom_range(min_d, max_d)) add_char(hex_char($urandom_range(0, 15)));
    end
  endfunction

  function automatic void build_well_formed();
    int unsigned n;
    int unsigned head;
    int unsigned max_d;
    addr_text.delete();
    max_d = $urandom_range(1, 4);
    if ($urandom_range(0, 2) == 0) begin
      n    = $urandom_range(0, 7);
      head = $urandom_range(0, n);
      push_groups(head, 1, max_d);
      add_char(CharColon);
      add_char(CharColon);
      push_groups(n - head, 1, max_d);
    end else begin
      push_groups($urandom_range(1, 8), $urandom_range(1, max_d), max_d);
    end
  endfunction

  task automatic send_char(logic [7:0] c, logic is_last);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    last_char_i <= is_last;
    do @(posedge clk_i); while (in_stall_o);
    parser_sb.note_char(c, is_last);
    chars_sent++;
  endtask

  task automatic send_address();
    for (int i = 0; i < addr_text.size(); i++) begin
      send_char(addr_text[i], i == addr_text.size() - 1);
    end
    addrs_sent++;
  endtask

  task automatic send_text(string s);
    addr_text.delete();
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
    send_address();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        parser_sb.check_addr(addr_high_o, addr_low_o, status_o);
        stall_left = calm ? 0 : $urandom_range(0, 4);
      end else if (out_valid_o && stall_left != 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  initial begin
    int unsigned kind;
    int unsigned pos;
    int unsigned len;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("::");
    send_text("fF::Aa");
    send_text(":::");
    send_text("12345");
    send_text(":9");
    addr_text = '{8'h00};
    send_address();
    addr_text = '{8'hFF, CharZero};
    send_address();

    while (chars_sent < 450 || addrs_sent < 20) begin
      calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      case (kind)
        6: begin
          addr_text.delete();
          push_groups(8, 4, 4);
          if ($urandom_range(0, 1)) begin
            add_char(hex_char($urandom_range(0, 15)));
          end else begin
            add_char(CharColon);
            push_groups(1, 1, 4);
          end
        end
        7: begin
          addr_text.delete();
          if ($urandom_range(0, 1)) begin
            pos = $urandom_range(0, 8);
            push_groups(pos, 1, 2);
            add_char(CharColon);
            add_char(CharColon);
            push_groups(8 - pos, 1, 2);
          end else begin
            push_groups(9, 1, 3);
          end
        end
        8: begin
          build_well_formed();
          pos = $urandom_range(0, addr_text.size());
          case ($urandom_range(0, 3))
            0: addr_text.insert(pos, 8'($urandom_range(0, 255)));
            1: addr_text.insert(pos, CharColon);
            2: addr_text.insert(pos, hex_char($urandom_range(0, 15)));
            default: add_char(CharColon);
          endcase
        end
        9: begin
          addr_text.delete();
          len = $urandom_range(1, 45);
          repeat (len) begin
            case ($urandom_range(0, 3))
              0, 1: add_char(8'($urandom_range(0, 255)));
              2: add_char(CharColon);
              default: add_char(hex_char($urandom_range(0, 15)));
            endcase
          end
        end
        default: build_well_formed();
      endcase
      send_address();
    end
    in_valid_i <= 1'b0;

    while (parser_sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (parser_sb.failures == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> sim.f
sv/ipv6p_pkg.sv
sv/ipv6_text_address_parser.sv
test/ipv6_text_address_parser_tb.sv
